/* rtl/sbsc_pkg.sv */
// sbsc_pkg: types and constants for the seeded byte substitution cipher
// used by the controller, datapath and top level
package sbsc_pkg;

  localparam int unsigned NumBytes  = 256;
  localparam int unsigned DrawTries = 4;
  localparam int unsigned MtMid     = 156;
  localparam logic [63:0] MtMult    = 64'd6364136223846793005;
  localparam logic [63:0] MtMatrix  = 64'hB5026F5AA96619E9;
  localparam logic [63:0] MtUpper   = 64'hFFFFFFFF80000000;
  localparam logic [63:0] MtLower   = 64'h000000007FFFFFFF;

  localparam logic [1:0] ReqRekey   = 2'd0;
  localparam logic [1:0] ReqEncrypt = 2'd1;

  localparam logic [1:0] StSubst    = 2'd0;
  localparam logic [1:0] StRekeyed  = 2'd1;
  localparam logic [1:0] StNotKeyed = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic [1:0] status;
    logic       last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_CLEAR,
    S_HASH_LOAD,
    S_HASH_RUN,
    S_HASH_MLO,
    S_HASH_MMID,
    S_HASH_MUL,
    S_HASH_FIN,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_step;     // write zero to used bit at sweep index
    logic clr_reset;    // reset sweep index
    logic hash_load;    // load hash from seed (hash_seed 1) or chain (0)
    logic hash_seed;
    logic hash_mix;     // w ^ (w>>62) then register
    logic hash_mul_lo;  // low partial product plus i
    logic hash_mul_mid; // first cross partial product
    logic hash_mul;     // second cross partial product, w updated
    logic hash_fin;     // temper and store chain
    logic tries_reset;
    logic try_next;
    logic used_rd;      // read used bit of candidate
    logic scan_reset;
    logic scan_step;
    logic write_pick;   // write tables, advance index
    logic idx_reset;
    logic lookup;
    logic set_keyed;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic used_hit;   // used bit of current candidate
    logic tries_left;
    logic scan_free;
    logic idx_last;
    logic keyed;
  } sts_t;

endpackage

/* rtl/seeded_byte_substitution_cipher.sv */
// seeded_byte_substitution_cipher: top level, controller plus datapath
// depends on sbsc_pkg, sbsc_ctrl, sbsc_dp, sbsc_ram
//
// channel  ports                        handshake
// in       in_item, start, busy         start && !busy
// out      out_item, out_valid          one-cycle strobe
// cfg      cfg_data, cfg_valid, cfg_ready  valid && ready
//
// encrypt/decrypt: result in the cycle after acceptance; busy while working
// rekey: used-bit sweep over all 256 bytes, then hashes of 156 rounds of mix and
//   three 32x32 partial products on one multiplier: one seed hash, then per byte
//   1 to 4 hashes with a check each, a free-byte scan if all collide, and a write
// reset clears control and the key seed; tables are undefined until first rekey
// seed writes wait while busy or an item is offered; the receiver cannot stall
module seeded_byte_substitution_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sbsc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output sbsc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         cfg_data
);
  import sbsc_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        done;
  logic [63:0] seed_r;

  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  sbsc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .req_type(in_item.req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  sbsc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .seed    (seed_r),
    .done    (done),
    .sts     (sts),
    .out_item(out_item)
  );

  assign out_valid = done;

`ifndef SYNTHESIS
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
  a_keyed_after_rekey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == StRekeyed) |=> sts.keyed)
    else $error("rekey did not key");
`endif
endmodule

/* rtl/sbsc_ram.sv */
// sbsc_ram: generic single port write, single read RAM with registered read
// no dependencies
module sbsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sbsc_ctrl.sv */
// sbsc_ctrl: sequencer for lookups and the rekey build
// depends on sbsc_pkg
module sbsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  sbsc_pkg::sts_t    sts,
  output sbsc_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import sbsc_pkg::*;

  state_t state_r, state_nxt;
  logic   chain_seed_r, chain_seed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chain_seed_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chain_seed_r <= chain_seed_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    chain_seed_nxt = chain_seed_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == ReqRekey) begin
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: state_nxt = S_IDLE;
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt      = S_HASH_LOAD;
          chain_seed_nxt = 1'b1;
        end
      end
      S_HASH_LOAD: state_nxt = S_HASH_RUN;
      S_HASH_RUN:  state_nxt = S_HASH_MLO;
      S_HASH_MLO:  state_nxt = S_HASH_MMID;
      S_HASH_MMID: state_nxt = S_HASH_MUL;
      S_HASH_MUL: begin
        if (sts.hash_last) begin
          state_nxt = S_HASH_FIN;
        end else begin
          state_nxt = S_HASH_RUN;
        end
      end
      S_HASH_FIN: begin
        if (chain_seed_r) begin
          chain_seed_nxt = 1'b0;
          state_nxt      = S_HASH_LOAD;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // used bit read lands this cycle
        if (!sts.used_hit) begin
          state_nxt = S_WRITE;
        end else if (sts.tries_left) begin
          state_nxt = S_HASH_LOAD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_free) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts.idx_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_HASH_LOAD;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.clr_reset   = 1'b1;
        cmd.idx_reset   = 1'b1;
        cmd.tries_reset = 1'b1;
        cmd.lookup      = start && (req_type != ReqRekey);
      end
      S_LOOKUP: done = 1'b1;
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_HASH_LOAD: begin
        cmd.hash_load = 1'b1;
        cmd.hash_seed = chain_seed_r;
      end
      S_HASH_RUN:  cmd.hash_mix = 1'b1;
      S_HASH_MLO:  cmd.hash_mul_lo = 1'b1;
      S_HASH_MMID: cmd.hash_mul_mid = 1'b1;
      S_HASH_MUL:  cmd.hash_mul = 1'b1;
      S_HASH_FIN: begin
        cmd.hash_fin = 1'b1;
        cmd.used_rd  = !chain_seed_r;
      end
      S_CHECK: begin
        cmd.try_next   = 1'b1;
        cmd.scan_reset = 1'b1;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_WRITE: begin
        cmd.write_pick  = 1'b1;
        cmd.tries_reset = 1'b1;
      end
      S_DONE: begin
        done          = 1'b1;
        cmd.set_keyed = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> $past(state_r) == S_IDLE)
    else $error("lookup entered from wrong state");
  a_write_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_pick |-> ($past(state_r) == S_CHECK || $past(state_r) == S_SCAN))
    else $error("table write without a pick");
`endif
endmodule

/* rtl/sbsc_dp.sv */
// sbsc_dp: hash unit, used-bit store, permutation tables and result register
// depends on sbsc_pkg and sbsc_ram
module sbsc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sbsc_pkg::cmd_t     cmd,
  input  sbsc_pkg::in_item_t in_item,
  input  logic [63:0]        seed,
  input  logic               done,
  output sbsc_pkg::sts_t     sts,
  output sbsc_pkg::out_item_t out_item
);
  import sbsc_pkg::*;

  // hash state
  logic [63:0] w_r, w_nxt, w0_r, w1_r, chain_r, mix_r, acc_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [7:0]  step_r;   // hash iteration index 1..156, ends at 157
  logic [8:0]  clr_r;    // clear sweep index, holds 256
  logic [7:0]  idx_r;
  logic [7:0]  scan_r;
  logic [1:0]  tries_r;
  logic        keyed_r;
  logic        used_hit_r;
  logic        used_we, used_wdata, used_rd_data;
  logic [7:0]  used_waddr, used_raddr;
  logic [7:0]  pick;
  logic [63:0] y, ya, t;
  logic        is_rekey_r, is_fwd_r, last_r;
  logic [7:0]  byte_r;
  logic [7:0]  fwd_rd, inv_rd;

  always_comb begin
    y  = (w0_r & MtUpper) | (w1_r & MtLower);
    ya = {1'b0, y[63:1]} ^ (y[0] ? MtMatrix : 64'd0);
    t  = w_r ^ ya;
    t  = t ^ ((t >> 29) & 64'h5555555555555555);
    t  = t ^ ((t << 17) & 64'h71D67FFFEDA60000);
    t  = t ^ ((t << 37) & 64'hFFF7EEE000000000);
    t  = t ^ (t >> 43);
    // one 32x32 multiplier shared by the three partial products
    mul_a = cmd.hash_mul ? mix_r[63:32] : mix_r[31:0];
    mul_b = cmd.hash_mul_mid ? MtMult[63:32] : MtMult[31:0];
    prod  = 64'(mul_a) * 64'(mul_b);
    w_nxt = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_load) begin
      w_r    <= cmd.hash_seed ? seed : chain_r;
      w0_r   <= cmd.hash_seed ? seed : chain_r;
      step_r <= 8'd1;
    end
    if (cmd.hash_mix) begin
      mix_r <= w_r ^ (w_r >> 62);
    end
    if (cmd.hash_mul_lo) begin
      acc_r <= prod + {56'd0, step_r};
    end
    if (cmd.hash_mul_mid) begin
      acc_r[63:32] <= acc_r[63:32] + prod[31:0];
    end
    if (cmd.hash_mul) begin
      w_r    <= w_nxt;
      step_r <= step_r + 8'd1;
      if (step_r == 8'd1) begin
        w1_r <= w_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r    <= '0;
      keyed_r    <= 1'b0;
      clr_r      <= '0;
      idx_r      <= '0;
      tries_r    <= '0;
      scan_r     <= '0;
      used_hit_r <= 1'b0;
    end else begin
      if (cmd.hash_fin) begin
        chain_r <= t;
      end
      if (cmd.try_next) begin
        used_hit_r <= used_rd_data;
      end
      if (cmd.clr_reset) begin
        clr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + 9'd1;
      end
      if (cmd.idx_reset) begin
        idx_r <= '0;
      end else if (cmd.write_pick) begin
        idx_r <= idx_r + 8'd1;
      end
      if (cmd.tries_reset) begin
        tries_r <= '0;
      end else if (cmd.try_next) begin
        tries_r <= tries_r + 2'd1;
      end
      if (cmd.scan_reset) begin
        scan_r <= '0;
      end else if (cmd.scan_step && used_rd_data) begin
        scan_r <= scan_r + 8'd1;
      end
      if (cmd.set_keyed) begin
        keyed_r <= 1'b1;
      end
    end
  end

  // candidate wins unless the scan found the pick
  assign pick = used_hit_r ? scan_r : chain_r[7:0];

  // used bits: sweep clears, table writes set; the scan reads one address ahead
  assign used_we    = cmd.clr_step || cmd.write_pick;
  assign used_waddr = cmd.write_pick ? pick : clr_r[7:0];
  assign used_wdata = cmd.write_pick;
  assign used_raddr = cmd.used_rd ? t[7:0] : (cmd.scan_reset ? 8'd0 : scan_r + 8'd1);

  sbsc_ram #(.Width(1), .Depth(NumBytes)) u_used (
    .clk  (clk),
    .we   (used_we),
    .waddr(used_waddr),
    .wdata(used_wdata),
    .raddr(used_raddr),
    .rdata(used_rd_data)
  );

  assign sts.clr_last   = (clr_r == 9'd255);
  assign sts.hash_last  = (step_r == 8'(MtMid));
  assign sts.used_hit   = used_rd_data;
  assign sts.tries_left = (tries_r != 2'(DrawTries - 1));
  assign sts.scan_free  = !used_rd_data;
  assign sts.idx_last   = (idx_r == 8'd255);
  assign sts.keyed      = keyed_r;

  sbsc_ram #(.Width(8), .Depth(NumBytes)) u_fwd (
    .clk  (clk),
    .we   (cmd.write_pick),
    .waddr(idx_r),
    .wdata(pick),
    .raddr(in_item.data_byte),
    .rdata(fwd_rd)
  );

  sbsc_ram #(.Width(8), .Depth(NumBytes)) u_inv (
    .clk  (clk),
    .we   (cmd.write_pick),
    .waddr(pick),
    .wdata(idx_r),
    .raddr(in_item.data_byte),
    .rdata(inv_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.lookup || cmd.clr_reset && cmd.idx_reset && !cmd.lookup) begin
      is_rekey_r <= (in_item.req_type == ReqRekey);
      is_fwd_r   <= (in_item.req_type == ReqEncrypt);
      last_r     <= in_item.last_in;
      byte_r     <= in_item.data_byte;
    end
  end

  always_comb begin
    out_item.last_out = last_r;
    if (is_rekey_r) begin
      out_item.result_byte = 8'd0;
      out_item.status      = StRekeyed;
    end else if (!keyed_r) begin
      out_item.result_byte = byte_r;
      out_item.status      = StNotKeyed;
    end else begin
      out_item.result_byte = is_fwd_r ? fwd_rd : inv_rd;
      out_item.status      = StSubst;
    end
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && used_rd_data) |-> scan_r != 8'd255)
    else $error("scan ran past last byte");
  a_keyed_stays: assert property (@(posedge clk) disable iff (!rst_n)
    keyed_r |=> keyed_r) else $error("keyed flag dropped");
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_item.status != 2'd3) else $error("bad status");
`endif
endmodule

/* dv/seeded_byte_substitution_cipher_tb.sv */
// testbench for seeded_byte_substitution_cipher: directed and random items with a
// self-contained table predictor (twister first-draw chain); depends on sbsc_pkg
`timescale 1ns / 1ps

module seeded_byte_substitution_cipher_tb;
  import sbsc_pkg::*;

  localparam logic [1:0] ReqDecrypt = 2'd2;
  localparam logic [1:0] ReqSpare   = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  seeded_byte_substitution_cipher u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [7:0]  fwd_tbl [256];
  logic [7:0]  inv_tbl [256];
  logic        byte_used [256];
  logic [63:0] chain;
  logic        keyed;
  logic [63:0] seed_reg;

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int        errors;
  int        n_results;
  int        n_rekeys;
  int        n_cfg_writes;
  int        gap_left;
  bit        no_idle;
  logic      item_taken;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mt_first(input logic [63:0] x);
    logic [63:0] w;
    logic [63:0] w1;
    logic [63:0] y;
    logic [63:0] ya;
    w  = x;
    w1 = '0;
    for (int i = 1; i <= MtMid; i++) begin
      w = MtMult * (w ^ (w >> 62)) + 64'(i);
      if (i == 1) w1 = w;
    end
    y  = (x & MtUpper) | (w1 & MtLower);
    ya = y >> 1;
    if (y[0]) ya = ya ^ MtMatrix;
    y = w ^ ya;
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

  task automatic build_tables();
    logic [7:0] pick;
    logic [7:0] cand;
    bit         found;
    for (int j = 0; j < NumBytes; j++) byte_used[j] = 1'b0;
    chain = mt_first(seed_reg);
    for (int i = 0; i < NumBytes; i++) begin
      found = 1'b0;
      pick  = '0;
      for (int t = 0; t < DrawTries && !found; t++) begin
        chain = mt_first(chain);
        cand  = chain[7:0];
        if (!byte_used[cand]) begin
          pick  = cand;
          found = 1'b1;
        end
      end
      // all draws collided: lowest free byte
      for (int j = 0; j < NumBytes && !found; j++) begin
        if (!byte_used[j]) begin
          pick  = 8'(j);
          found = 1'b1;
        end
      end
      fwd_tbl[i]      = pick;
      inv_tbl[pick]   = 8'(i);
      byte_used[pick] = 1'b1;
    end
    keyed = 1'b1;
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t r;
    r.last_out = it.last_in;
    if (it.req_type == ReqRekey) begin
      build_tables();
      r.result_byte = '0;
      r.status      = StRekeyed;
      n_rekeys++;
    end else if (!keyed) begin
      r.result_byte = it.data_byte;
      r.status      = StNotKeyed;
    end else if (it.req_type == ReqEncrypt) begin
      r.result_byte = fwd_tbl[it.data_byte];
      r.status      = StSubst;
    end else begin
      // decrypt and the spare code both read the inverse table
      r.result_byte = inv_tbl[it.data_byte];
      r.status      = StSubst;
    end
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // monitor: accepts items, config writes and results at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_data;
        n_cfg_writes++;
      end
      if (start && !busy) predict_item(in_item);
      if (out_valid) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", int'(out_item), -1);
        end else begin
          want = expected_q.pop_front();
          if (out_item.result_byte !== want.result_byte)
            report_mismatch("result_byte", int'(out_item.result_byte),
                            int'(want.result_byte));
          if (out_item.status !== want.status)
            report_mismatch("status", int'(out_item.status), int'(want.status));
          if (out_item.last_out !== want.last_out)
            report_mismatch("last_out", int'(out_item.last_out), int'(want.last_out));
        end
      end
    end
  end

  // driver: one item in flight, random gap drawn per item unless no_idle is set
  always @(negedge clk) begin
    logic     nxt_start;
    in_item_t nxt_item;
    nxt_start = start;
    nxt_item  = in_item;
    if (!rst_n) begin
      nxt_start = 1'b0;
      gap_left  = 0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_start = 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt_item  = pending_q.pop_front();
        nxt_start = 1'b1;
        gap_left  = no_idle ? 0 : $urandom_range(0, 10);
      end else begin
        nxt_start = 1'b0;
      end
    end
    start   <= nxt_start;
    in_item <= nxt_item;
  end

  task automatic add_item(input logic [1:0] req, input logic [7:0] b, input logic last);
    in_item_t it;
    it.req_type  = req;
    it.data_byte = b;
    it.last_in   = last;
    pending_q.push_back(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_q.size() > 0 || start || busy || expected_q.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] v);
    int seen;
    seen = n_cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    while (n_cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random buffers, mostly substitutions, optionally one rekey in the middle
  task automatic add_buffers(input int count, input bit with_rekey);
    int          len;
    logic [1:0]  req;
    int          added;
    added = 0;
    while (added < count) begin
      len = $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       req = ReqSpare;
          1, 2, 3: req = ReqDecrypt;
          default: req = ReqEncrypt;
        endcase
        add_item(req, 8'($urandom_range(0, 255)), k == len - 1);
      end
      added += len;
      if (with_rekey && added >= count / 2) begin
        add_item(ReqRekey, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        with_rekey = 1'b0;
      end
    end
  endtask

  initial begin
    #200_000_000;
    $display("seeded_byte_substitution_cipher verification failed");
    $finish;
  end

  initial begin
    logic [63:0] rseed;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors = 0; n_results = 0; n_rekeys = 0; n_cfg_writes = 0;
    keyed = 1'b0; chain = '0; seed_reg = '0; no_idle = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // not keyed yet: bytes pass through
    add_item(ReqEncrypt, 8'h00, 1'b0);
    add_item(ReqDecrypt, 8'hFF, 1'b1);
    add_item(ReqSpare,   8'hA5, 1'b0);
    add_item(ReqEncrypt, 8'h5A, 1'b1);
    wait_drained();

    // zero seed, then rekey twice (rebuild while keyed)
    write_seed(64'h0);
    add_item(ReqRekey,   8'hFF, 1'b1);
    add_item(ReqEncrypt, 8'h00, 1'b0);
    add_item(ReqEncrypt, 8'hFF, 1'b1);
    add_item(ReqDecrypt, 8'h00, 1'b0);
    add_item(ReqDecrypt, 8'hFF, 1'b1);
    add_item(ReqSpare,   8'h3C, 1'b0);
    add_item(ReqRekey,   8'h00, 1'b0);
    add_item(ReqEncrypt, 8'h80, 1'b1);
    add_item(ReqDecrypt, 8'h7F, 1'b0);
    wait_drained();

    // all-ones seed, back-to-back items
    write_seed({64{1'b1}});
    no_idle = 1'b1;
    add_item(ReqRekey, 8'h00, 1'b0);
    add_buffers(450, 1'b0);
    wait_drained();

    // random seed, random gaps
    no_idle = 1'b0;
    rseed = {32'($urandom), 32'($urandom)};
    write_seed(rseed);
    add_item(ReqRekey, 8'h00, 1'b1);
    add_buffers(550, 1'b0);
    wait_drained();

    rseed = {32'($urandom), 32'($urandom)};
    write_seed(rseed);
    add_item(ReqRekey, 8'h00, 1'b0);
    add_buffers(580, 1'b1);
    wait_drained();

    repeat (20) @(posedge clk);
    if (expected_q.size() > 0) begin
      $display("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("covered %0d results, %0d table rebuilds, %0d seed writes", n_results,
             n_rekeys, n_cfg_writes);
    if (errors == 0) begin
      $display("seeded_byte_substitution_cipher verification clean");
    end else begin
      $display("seeded_byte_substitution_cipher verification failed");
    end
    $finish;
  end

endmodule
